>>> design/gray_alpha_blend_compositor_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gray alpha blend compositor
// Concurrent checks that drop out of the build when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GRAY_ALPHA_BLEND_COMPOSITOR_TOP_DEFINES_SVH
`define GRAY_ALPHA_BLEND_COMPOSITOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define GABC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gabc: implication check failed");
`define GABC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gabc: next-cycle check failed");
`else
`define GABC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GABC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/gabc_pkg.sv
// ----------------------------------------------------------------------------
// gabc_pkg
// Shared codes, payload structs and the rounded divide-by-255 multiply.
// ----------------------------------------------------------------------------
`default_nettype none
package gabc_pkg;

   localparam int MODE_W   = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [MODE_W-1:0] MODE_OVER    = 4'd0;
   localparam logic [MODE_W-1:0] MODE_MULT    = 4'd1;
   localparam logic [MODE_W-1:0] MODE_DIVIDE  = 4'd2;
   localparam logic [MODE_W-1:0] MODE_DARKEN  = 4'd3;
   localparam logic [MODE_W-1:0] MODE_LIGHTEN = 4'd4;
   localparam logic [MODE_W-1:0] MODE_SCREEN  = 4'd5;
   localparam logic [MODE_W-1:0] MODE_OVERLAY = 4'd6;
   localparam logic [MODE_W-1:0] MODE_DODGE   = 4'd7;
   localparam logic [MODE_W-1:0] MODE_BURN    = 4'd8;
   localparam logic [MODE_W-1:0] MODE_COPY    = 4'd9;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 4'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_MODE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_OPACITY = 1'b1;

   localparam logic [7:0] FULL = 8'hFF;
   localparam logic [7:0] OPACITY_RESET = 8'hFF;

   typedef enum logic [1:0] {
      KIND_DST,
      KIND_SRC,
      KIND_CLEAR,
      KIND_BLEND
   } kind_type;

   typedef enum logic [1:0] {
      COLOR_DIRECT,
      COLOR_QUOT,
      COLOR_BURN
   } color_type;

   typedef struct packed {
      kind_type   kind;
      logic       over;
      logic [7:0] oa;
      logic [7:0] na;
      logic       use_div;
      logic [7:0] sa;
      logic [7:0] m_pre;
      logic       sat;
      color_type  csrc;
      logic [7:0] sg;
      logic [7:0] dg;
      logic       last;
   } mid_type;

   typedef struct packed {
      kind_type   kind;
      logic       over;
      logic [7:0] oa;
      logic       use_div;
      logic [7:0] sa;
      logic [7:0] m;
      logic [7:0] sg;
      logic [7:0] dg;
      logic       last;
   } late_type;

   // c = a*b + 0x80, result = ((c >>> 8) + c) >>> 8 with floor shifts
   function automatic logic signed [23:0] mul255(input logic signed [11:0] a,
                                                 input logic signed [11:0] b);
      logic signed [23:0] c;
      c = a * b + 24'sd128;
      return ((c >>> 8) + c) >>> 8;
   endfunction

endpackage
`default_nettype wire

>>> design/gray_alpha_blend_compositor_top.sv
// ----------------------------------------------------------------------------
// gray_alpha_blend_compositor_top
// Gray+alpha pixel compositor with eleven blend modes and layer opacity.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: a source and a destination gray+alpha pixel plus
//   a last flag. rsp_* returns the new destination pixel for that item, in
//   order, one result per item. Each channel moves an item on a clock edge
//   with valid high and stall low.
//   csr_we writes csr_data into the register csr_index selects: index 0 is
//   the blend mode, index 1 the layer opacity. Write only while idle.
//   The item passes fifteen register stages: two front stages, four stages
//   of the mode-color divider, eight stages of the alpha-ratio divider (two
//   quotient bits per stage each) and the output register. Throughput is
//   one item per cycle while rsp_stall is low; every stage holds a valid bit.
//   When rsp_stall is high the output register holds its item, stages fill
//   up behind it and req_stall rises only once every stage is occupied.
//   Reset (synchronous, active high) empties the pipeline, sets the mode to
//   over and the opacity to 255.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gray_alpha_blend_compositor_top_defines.svh"
module gray_alpha_blend_compositor_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_src_gray,
   input  wire logic [7:0]                       req_src_alpha,
   input  wire logic [7:0]                       req_dst_gray,
   input  wire logic [7:0]                       req_dst_alpha,
   input  wire logic                             req_last_pixel,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [7:0]                            rsp_out_gray,
   output logic [7:0]                            rsp_out_alpha,
   output logic                                  rsp_out_last,
   input  wire logic                             csr_we,
   input  wire logic [gabc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [gabc_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int MID_W  = $bits(gabc_pkg::mid_type);
   localparam int LATE_W = $bits(gabc_pkg::late_type);

   logic [gabc_pkg::MODE_W-1:0] mode_ff;
   logic [7:0]                  opacity_ff;

   logic              front_ready, mid_valid, mid_ready;
   gabc_pkg::mid_type mid_side;
   logic [8:0]        mid_rem, mid_den;

   logic              cdiv_valid, cdiv_ready;
   logic [7:0]        cdiv_quot;
   logic [MID_W-1:0]  cdiv_side;
   gabc_pkg::mid_type cmid;

   gabc_pkg::late_type late_in;
   logic [15:0]        adiv_num;
   logic [7:0]         adiv_den, qsat;

   logic              adiv_valid, adiv_ready;
   logic [15:0]       adiv_quot;
   logic [LATE_W-1:0] adiv_side;
   logic              out_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= gabc_pkg::MODE_OVER;
         opacity_ff <= gabc_pkg::OPACITY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            gabc_pkg::CSR_IDX_MODE:    mode_ff    <= csr_data[gabc_pkg::MODE_W-1:0];
            gabc_pkg::CSR_IDX_OPACITY: opacity_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stall back toward the requester only when the whole pipeline is full
   assign req_stall = !front_ready;
   assign out_ready = !rsp_stall;

   gabc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_sg     (req_src_gray),
      .in_sa     (req_src_alpha),
      .in_dg     (req_dst_gray),
      .in_da     (req_dst_alpha),
      .in_last   (req_last_pixel),
      .mode      (mode_ff),
      .opacity   (opacity_ff),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_mid   (mid_side),
      .out_rem   (mid_rem),
      .out_den   (mid_den)
   );

   // mode color quotient: n * 256 / den, only needed when n < den
   gabc_div #(
      .QW (8),
      .DW (9),
      .SW (MID_W)
   ) u_cdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_rem    (mid_rem),
      .in_num    (8'd0),
      .in_den    (mid_den),
      .in_side   (mid_side),
      .out_valid (cdiv_valid),
      .out_ready (cdiv_ready),
      .out_quot  (cdiv_quot),
      .out_side  (cdiv_side)
   );

   // resolve the mode color, then set up the alpha ratio (sa*255 + na/2) / na
   always_comb begin
      cmid = gabc_pkg::mid_type'(cdiv_side);
      qsat = cmid.sat ? gabc_pkg::FULL : cdiv_quot;
      case (cmid.csrc)
         gabc_pkg::COLOR_QUOT: late_in.m = qsat;
         gabc_pkg::COLOR_BURN: late_in.m = gabc_pkg::FULL - qsat;
         default:              late_in.m = cmid.m_pre;
      endcase
      late_in.kind    = cmid.kind;
      late_in.over    = cmid.over;
      late_in.oa      = cmid.oa;
      late_in.use_div = cmid.use_div;
      late_in.sa      = cmid.sa;
      late_in.sg      = cmid.sg;
      late_in.dg      = cmid.dg;
      late_in.last    = cmid.last;
      adiv_num = ({cmid.sa, 8'd0} - {8'd0, cmid.sa}) + {9'd0, cmid.na[7:1]};
      adiv_den = cmid.use_div ? cmid.na : 8'd1;
   end

   gabc_div #(
      .QW (16),
      .DW (8),
      .SW (LATE_W)
   ) u_adiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cdiv_valid),
      .in_ready  (cdiv_ready),
      .in_rem    (8'd0),
      .in_num    (adiv_num),
      .in_den    (adiv_den),
      .in_side   (late_in),
      .out_valid (adiv_valid),
      .out_ready (adiv_ready),
      .out_quot  (adiv_quot),
      .out_side  (adiv_side)
   );

   gabc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (adiv_valid),
      .in_ready  (adiv_ready),
      .in_quot   (adiv_quot[7:0]),
      .in_late   (gabc_pkg::late_type'(adiv_side)),
      .out_valid (rsp_valid),
      .out_ready (out_ready),
      .out_gray  (rsp_out_gray),
      .out_alpha (rsp_out_alpha),
      .out_last  (rsp_out_last)
   );

   // input stalls only behind a stalled output
   `GABC_ASSERT_IMP(a_stall_source, clock, reset, req_stall, rsp_valid && rsp_stall)
   // a draining output frees the whole pipeline
   `GABC_ASSERT_IMP(a_drain_ready, clock, reset, rsp_valid && !rsp_stall, !req_stall)
   // clear mode yields a transparent black pixel
   `GABC_ASSERT_IMP(a_clear_zero, clock, reset, rsp_valid && mode_ff == gabc_pkg::MODE_CLEAR,
                    rsp_out_gray == 8'd0 && rsp_out_alpha == 8'd0)
   // a blocked front item keeps its payload
   `GABC_ASSERT_NXT(a_mid_hold, clock, reset, mid_valid && !mid_ready,
                    mid_valid && $stable(mid_side))

endmodule
`default_nettype wire

>>> design/gabc_front.sv
// ----------------------------------------------------------------------------
// gabc_front
// Two stages: alpha scaling and mode products, then coverage and divide setup.
// ----------------------------------------------------------------------------
`default_nettype none
module gabc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [7:0]                    in_sg,
   input  wire logic [7:0]                    in_sa,
   input  wire logic [7:0]                    in_dg,
   input  wire logic [7:0]                    in_da,
   input  wire logic                          in_last,
   input  wire logic [gabc_pkg::MODE_W-1:0]   mode,
   input  wire logic [7:0]                    opacity,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output gabc_pkg::mid_type                  out_mid,
   output logic [8:0]                         out_rem,
   output logic [8:0]                         out_den
);

   // stage 1 registers
   logic                        v1_ff;
   logic [7:0]                  sg1_ff, sa1_ff, dg1_ff, da1_ff;
   logic                        last1_ff;
   logic [gabc_pkg::MODE_W-1:0] mode1_ff;
   logic                        zero1_ff;
   logic [7:0]                  saeff1_ff, pmult1_ff, pscr1_ff;
   logic [9:0]                  pov1_ff;
   logic                        en1, en2;

   // stage 2 registers
   logic                        v2_ff;
   gabc_pkg::mid_type           mid2_ff, mid2_in;
   logic [8:0]                  rem2_ff, rem2_in, den2_ff, den2_in;

   logic [7:0]         sa_min, sa_sel, sa_op, saeff1_in, pmult1_in, pscr1_in;
   logic [9:0]         pov1_in;
   logic signed [23:0] m_op, m_mult, m_scr, m_ov, m_na, m_ovl;
   logic [7:0]         na, ovl;
   logic [10:0]        ov_arg;
   logic [7:0]         n8;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      sa_min = (in_sa < in_da) ? in_sa : in_da;
      sa_sel = (mode == gabc_pkg::MODE_OVER) ? in_sa : sa_min;
      m_op   = gabc_pkg::mul255($signed({4'b0, in_sa}), $signed({4'b0, opacity}));
      sa_op  = m_op[7:0];
      saeff1_in = (opacity != gabc_pkg::FULL) ? sa_op : sa_sel;
      m_mult = gabc_pkg::mul255($signed({4'b0, in_sg}), $signed({4'b0, in_dg}));
      pmult1_in = m_mult[7:0];
      m_scr  = gabc_pkg::mul255($signed({4'b0, gabc_pkg::FULL - in_dg}),
                                $signed({4'b0, gabc_pkg::FULL - in_sg}));
      pscr1_in = gabc_pkg::FULL - m_scr[7:0];
      m_ov   = gabc_pkg::mul255($signed({3'b0, in_sg, 1'b0}),
                                $signed({4'b0, gabc_pkg::FULL - in_dg}));
      pov1_in = m_ov[9:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= in_valid;
      end
      if (en1) begin
         sg1_ff    <= in_sg;
         sa1_ff    <= in_sa;
         dg1_ff    <= in_dg;
         da1_ff    <= in_da;
         last1_ff  <= in_last;
         mode1_ff  <= mode;
         zero1_ff  <= (sa_sel == 8'd0);
         saeff1_ff <= saeff1_in;
         pmult1_ff <= pmult1_in;
         pscr1_ff  <= pscr1_in;
         pov1_ff   <= pov1_in;
      end
   end

   always_comb begin
      m_na   = gabc_pkg::mul255($signed({4'b0, gabc_pkg::FULL - da1_ff}),
                                $signed({4'b0, saeff1_ff}));
      na     = da1_ff + m_na[7:0];
      ov_arg = {3'b0, dg1_ff} + {1'b0, pov1_ff};
      m_ovl  = gabc_pkg::mul255($signed({4'b0, dg1_ff}), $signed({1'b0, ov_arg}));
      ovl    = m_ovl[7:0];

      mid2_in.over    = (mode1_ff == gabc_pkg::MODE_OVER);
      mid2_in.na      = na;
      mid2_in.use_div = (da1_ff != gabc_pkg::FULL) && (na != 8'd0);
      mid2_in.sa      = saeff1_ff;
      mid2_in.sg      = sg1_ff;
      mid2_in.dg      = dg1_ff;
      mid2_in.last    = last1_ff;

      if (mode1_ff == gabc_pkg::MODE_COPY) begin
         mid2_in.kind = gabc_pkg::KIND_SRC;
         mid2_in.oa   = sa1_ff;
      end else if (mode1_ff == gabc_pkg::MODE_CLEAR) begin
         mid2_in.kind = gabc_pkg::KIND_CLEAR;
         mid2_in.oa   = 8'd0;
      end else if (mode1_ff > gabc_pkg::MODE_BURN || zero1_ff) begin
         mid2_in.kind = gabc_pkg::KIND_DST;
         mid2_in.oa   = da1_ff;
      end else if (mode1_ff == gabc_pkg::MODE_OVER && saeff1_ff == gabc_pkg::FULL) begin
         mid2_in.kind = gabc_pkg::KIND_SRC;
         mid2_in.oa   = sa1_ff;
      end else begin
         mid2_in.kind = gabc_pkg::KIND_BLEND;
         mid2_in.oa   = (da1_ff == gabc_pkg::FULL) ? da1_ff : na;
      end

      case (mode1_ff)
         gabc_pkg::MODE_MULT:    mid2_in.m_pre = pmult1_ff;
         gabc_pkg::MODE_DARKEN:  mid2_in.m_pre = (sg1_ff < dg1_ff) ? sg1_ff : dg1_ff;
         gabc_pkg::MODE_LIGHTEN: mid2_in.m_pre = (sg1_ff > dg1_ff) ? sg1_ff : dg1_ff;
         gabc_pkg::MODE_SCREEN:  mid2_in.m_pre = pscr1_ff;
         gabc_pkg::MODE_OVERLAY: mid2_in.m_pre = ovl;
         default:                mid2_in.m_pre = sg1_ff;
      endcase

      case (mode1_ff)
         gabc_pkg::MODE_DIVIDE, gabc_pkg::MODE_DODGE: mid2_in.csrc = gabc_pkg::COLOR_QUOT;
         gabc_pkg::MODE_BURN:                         mid2_in.csrc = gabc_pkg::COLOR_BURN;
         default:                                     mid2_in.csrc = gabc_pkg::COLOR_DIRECT;
      endcase

      n8      = (mode1_ff == gabc_pkg::MODE_BURN) ? (gabc_pkg::FULL - dg1_ff) : dg1_ff;
      den2_in = (mode1_ff == gabc_pkg::MODE_DODGE) ? (9'd256 - {1'b0, sg1_ff})
                                                   : ({1'b0, sg1_ff} + 9'd1);
      rem2_in = {1'b0, n8};
      mid2_in.sat = (rem2_in >= den2_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         mid2_ff <= mid2_in;
         rem2_ff <= rem2_in;
         den2_ff <= den2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_mid   = mid2_ff;
   assign out_rem   = rem2_ff;
   assign out_den   = den2_ff;

endmodule
`default_nettype wire

>>> design/gabc_div.sv
// ----------------------------------------------------------------------------
// gabc_div
// Pipelined restoring divider, two quotient bits per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none
module gabc_div #(
   parameter int QW = 8,
   parameter int DW = 9,
   parameter int SW = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [DW-1:0] in_rem,
   input  wire logic [QW-1:0] in_num,
   input  wire logic [DW-1:0] in_den,
   input  wire logic [SW-1:0] in_side,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [QW-1:0]      out_quot,
   output logic [SW-1:0]      out_side
);

   localparam int NS = QW / 2;

   logic [NS-1:0]   v_ff;
   logic [NS:0]     ready;
   logic [DW-1:0]   rem_ff [NS];
   logic [QW-1:0]   nq_ff  [NS];
   logic [DW-1:0]   den_ff [NS];
   logic [SW-1:0]   side_ff[NS];

   assign ready[NS] = out_ready;

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic          valid_src;
      logic [DW-1:0] rem_src, den_src, rem_in;
      logic [QW-1:0] nq_src, nq_in;
      logic [SW-1:0] side_src;

      if (g == 0) begin : g_head
         assign valid_src = in_valid;
         assign rem_src   = in_rem;
         assign nq_src    = in_num;
         assign den_src   = in_den;
         assign side_src  = in_side;
      end else begin : g_body
         assign valid_src = v_ff[g-1];
         assign rem_src   = rem_ff[g-1];
         assign nq_src    = nq_ff[g-1];
         assign den_src   = den_ff[g-1];
         assign side_src  = side_ff[g-1];
      end

      assign ready[g] = !v_ff[g] || ready[g+1];

      always_comb begin
         logic [DW:0] t;
         rem_in = rem_src;
         nq_in  = nq_src;
         for (int k = 0; k < 2; k++) begin
            t     = {rem_in, nq_in[QW-1]};
            nq_in = {nq_in[QW-2:0], 1'b0};
            if (t >= {1'b0, den_src}) begin
               t        = t - {1'b0, den_src};
               nq_in[0] = 1'b1;
            end
            rem_in = t[DW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[g] <= 1'b0;
         end else if (ready[g]) begin
            v_ff[g] <= valid_src;
         end
         if (ready[g]) begin
            rem_ff[g]  <= rem_in;
            nq_ff[g]   <= nq_in;
            den_ff[g]  <= den_src;
            side_ff[g] <= side_src;
         end
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = v_ff[NS-1];
   assign out_quot  = nq_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule
`default_nettype wire

>>> design/gabc_back.sv
// ----------------------------------------------------------------------------
// gabc_back
// Final gray mix and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module gabc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [7:0]         in_quot,
   input  wire gabc_pkg::late_type in_late,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [7:0]              out_gray,
   output logic [7:0]              out_alpha,
   output logic                    out_last
);

   logic               valid_ff;
   logic [7:0]         gray_ff, gray_in, alpha_ff;
   logic               last_ff;
   logic [7:0]         w;
   logic signed [11:0] diff;
   logic signed [23:0] prod;
   logic [7:0]         mixv;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      w    = in_late.use_div ? in_quot : in_late.sa;
      diff = $signed({4'b0, in_late.m}) - $signed({4'b0, in_late.dg});
      prod = gabc_pkg::mul255(diff, $signed({4'b0, w}));
      mixv = prod[7:0] + in_late.dg;
      case (in_late.kind)
         gabc_pkg::KIND_DST:   gray_in = in_late.dg;
         gabc_pkg::KIND_SRC:   gray_in = in_late.sg;
         gabc_pkg::KIND_CLEAR: gray_in = 8'd0;
         default: begin
            gray_in = (in_late.over && w == gabc_pkg::FULL) ? in_late.sg : mixv;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         gray_ff  <= gray_in;
         alpha_ff <= in_late.oa;
         last_ff  <= in_late.last;
      end
   end

   assign out_valid = valid_ff;
   assign out_gray  = gray_ff;
   assign out_alpha = alpha_ff;
   assign out_last  = last_ff;

endmodule
`default_nettype wire

>>> tb/gray_alpha_blend_compositor_top_tb.sv
// ----------------------------------------------------------------------------
// Gray alpha blend compositor testbench
// Drives source/destination pixel items through every blend mode and a range
// of layer opacities, predicts each new destination pixel in order and checks
// it field by field, under random idling on both sides and long stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module gray_alpha_blend_compositor_top_tb;
   import gabc_pkg::*;

   typedef struct packed {
      logic [7:0] sg;
      logic [7:0] sa;
      logic [7:0] dg;
      logic [7:0] da;
      logic       last;
   } pixel_pair_t;

   typedef struct packed {
      logic [7:0] gray;
      logic [7:0] alpha;
      logic       last;
   } pixel_out_t;

   localparam int LATENCY = 15;
   localparam int CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_src_gray = '0, req_src_alpha = '0, req_dst_gray = '0, req_dst_alpha = '0;
   logic req_last_pixel = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_out_gray, rsp_out_alpha;
   logic rsp_out_last;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   gray_alpha_blend_compositor_top dut (.*);

   // 10-unit clock period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the registers
   logic [3:0] cur_mode = MODE_OVER;
   logic [7:0] cur_opacity = 8'd255;

   pixel_pair_t pending_pixels[$];
   pixel_out_t  expected_pixels[$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;       // cycles left of a long receiver stall

   function automatic int rmul(int a, int b);
      int c;
      c = a * b + 'h80;
      return ((c >>> 8) + c) >>> 8;
   endfunction

   function automatic int rdiv(int a, int b);
      return ((a * 255 + b / 2) / b) & 'hFF;
   endfunction

   function automatic int blend_mix(int m, int d, int w);
      return (rmul(m - d, w) + d) & 'hFF;
   endfunction

   function automatic int mode_gray(logic [3:0] mode, int s, int d);
      int t;
      case (mode)
         MODE_MULT:    return rmul(s, d) & 'hFF;
         MODE_DIVIDE: begin
            t = (d * 256) / (s + 1);
            return t > 255 ? 255 : t;
         end
         MODE_DARKEN:  return s < d ? s : d;
         MODE_LIGHTEN: return s > d ? s : d;
         MODE_SCREEN:  return (255 - rmul(255 - d, 255 - s)) & 'hFF;
         MODE_OVERLAY: return rmul(d, d + rmul(2 * s, 255 - d)) & 'hFF;
         MODE_DODGE: begin
            t = (d * 256) / (256 - s);
            return t > 255 ? 255 : t;
         end
         default: begin
            t = ((255 - d) * 256) / (s + 1);
            if (t > 255) t = 255;
            return 255 - t;
         end
      endcase
   endfunction

   function automatic pixel_out_t composite(pixel_pair_t p);
      pixel_out_t r;
      int sa, w, na;
      r.gray = p.dg;
      r.alpha = p.da;
      r.last = p.last;
      if (cur_mode == MODE_COPY) begin
         r.gray = p.sg;
         r.alpha = p.sa;
      end else if (cur_mode == MODE_CLEAR) begin
         r.gray = 0;
         r.alpha = 0;
      end else if (cur_mode <= MODE_BURN) begin
         sa = (cur_mode == MODE_OVER) ? p.sa : (p.sa < p.da ? p.sa : p.da);
         if (sa != 0) begin
            if (cur_opacity != 8'd255) sa = rmul(p.sa, cur_opacity) & 'hFF;
            if (cur_mode == MODE_OVER && sa == 255) begin
               r.gray = p.sg;
               r.alpha = p.sa;
            end else begin
               w = sa;
               if (p.da != 8'd255) begin
                  na = (p.da + rmul(255 - p.da, sa)) & 'hFF;
                  r.alpha = na;
                  if (na != 0) w = rdiv(sa, na);
               end
               if (cur_mode == MODE_OVER)
                  r.gray = (w == 255) ? p.sg : blend_mix(p.sg, p.dg, w);
               else
                  r.gray = blend_mix(mode_gray(cur_mode, p.sg, p.dg), p.dg, w);
            end
         end
      end
      return r;
   endfunction

   // append one item to the queue of pending items
   task automatic queue_pixel(pixel_pair_t p);
      pending_pixels.insert(pending_pixels.size(), p);
   endtask

   // driver: predict on acceptance, then advance to the next item
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_pixels.insert(expected_pixels.size(), composite(
               {req_src_gray, req_src_alpha, req_dst_gray, req_dst_alpha, req_last_pixel}));
         if (!req_valid || !req_stall) begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               pixel_pair_t p;
               p = pending_pixels.pop_front();
               req_valid <= 1'b1;
               {req_src_gray, req_src_alpha, req_dst_gray, req_dst_alpha, req_last_pixel} <= p;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall: random, or held for a long stretch when asked
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result gray=%0d alpha=%0d last=%0d", $time,
                     rsp_out_gray, rsp_out_alpha, rsp_out_last);
            errors++;
         end else begin
            pixel_out_t e;
            e = expected_pixels.pop_front();
            if (rsp_out_gray !== e.gray) begin
               $display("%0t: gray expected %0d actual %0d", $time, e.gray, rsp_out_gray);
               errors++;
            end
            if (rsp_out_alpha !== e.alpha) begin
               $display("%0t: alpha expected %0d actual %0d", $time, e.alpha, rsp_out_alpha);
               errors++;
            end
            if (rsp_out_last !== e.last) begin
               $display("%0t: last expected %0d actual %0d", $time, e.last, rsp_out_last);
               errors++;
            end
         end
      end
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [7:0] pick_alpha();
      case ($urandom_range(5))
         0: return 8'd0;
         1: return 8'd255;
         2: return $urandom_range(1, 3);
         3: return $urandom_range(252, 254);
         default: return $urandom_range(255);
      endcase
   endfunction

   task automatic queue_random(int count);
      pixel_pair_t p;
      repeat (count) begin
         p.sg = $urandom_range(255);
         p.sa = pick_alpha();
         p.dg = $urandom_range(255);
         p.da = pick_alpha();
         p.last = ($urandom_range(15) == 0);
         queue_pixel(p);
      end
   endtask

   task automatic drain();
      while (pending_pixels.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // write one register at an idle point, keeping the predictor copy in step
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_IDX_MODE) cur_mode = val[3:0];
      else cur_opacity = val;
      @(posedge clock);
   endtask

   logic [7:0] opacity_set[5] = '{8'd255, 8'd0, 8'd128, 8'd1, 8'd254};

   initial begin
      logic [3:0] m;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes under reset settings (over, opaque layer)
      queue_pixel({8'd0,   8'd0,   8'd255, 8'd255, 1'b0});
      queue_pixel({8'd255, 8'd255, 8'd0,   8'd0,   1'b1});
      queue_pixel({8'd200, 8'd128, 8'd10,  8'd255, 1'b0});
      queue_pixel({8'd10,  8'd128, 8'd200, 8'd0,   1'b0});
      queue_pixel({8'd170, 8'd85,  8'd85,  8'd170, 1'b1});
      drain();
      // every mode, including unused codes, with a few extreme pixels each
      for (int md = 0; md < 16; md++) begin
         write_reg(CSR_IDX_MODE, md);
         queue_pixel({8'd255, 8'd255, 8'd255, 8'd255, 1'b0});
         queue_pixel({8'd0,   8'd200, 8'd255, 8'd100, 1'b1});
         queue_pixel({8'd128, 8'd100, 8'd64,  8'd200, 1'b0});
         drain();
      end

      // random phases over every mode and several opacities and idling mixes
      for (int ph = 0; ph < 44; ph++) begin
         m = (ph < 11) ? ph : $urandom_range(15);
         if (ph % 11 == 10) m = $urandom_range(10, 15);
         write_reg(CSR_IDX_MODE, m);
         write_reg(CSR_IDX_OPACITY, (ph < 20) ? opacity_set[ph % 5] : $urandom_range(255));
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         if (ph == 6) hold_off = 200;   // fill the pipeline and push back on input
         queue_random(40);
         drain();
      end

      // full-rate burst against a long stall with the sender never pausing
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_reg(CSR_IDX_MODE, MODE_OVERLAY);
      write_reg(CSR_IDX_OPACITY, 8'd255);
      hold_off = 300;
      queue_random(40);
      drain();

      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire

>>> sim.f
+incdir+design
design/gabc_pkg.sv
design/gabc_front.sv
design/gabc_div.sv
design/gabc_back.sv
design/gray_alpha_blend_compositor_top.sv
tb/gray_alpha_blend_compositor_top_tb.sv
